@@ hdl/twodom_pkg.sv @@
// Shared constants, tables and helpers for the tracking-wheel odometry block.
package twodom_pkg;

  localparam int DATA_W       = 32;             // data word
  localparam int CFG_IDX_W    = 3;
  localparam int ANG_W        = DATA_W + 1;     // CORDIC angle input, Q8.24 plus growth
  localparam int RES_W        = 29;             // reduced angle residual
  localparam int CS_W         = 34;             // sine / cosine, Q2.30 with headroom
  localparam int CH_W         = CS_W + 1;       // chord factor 2*sin
  localparam int NUM_W        = 66;             // dividend width, even
  localparam int DEN_W        = DATA_W + 1;     // divisor width
  localparam int MUL_W        = 36;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int OFF_W        = 36;             // offset term after rounding
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int RED_STEPS    = 6;              // 2*pi*2^k subtractions, k = 5..0
  localparam int RED_W        = $clog2(RED_STEPS);

  localparam logic signed [RES_W-1:0] PI_Q24      = 29'sd52707179;
  localparam logic signed [RES_W-1:0] HALF_PI_Q24 = 29'sd26353589;
  localparam logic signed [RES_W-1:0] TWO_PI_Q24  = 29'sd105414358;
  localparam logic signed [CS_W-1:0]  CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [MUL_W-1:0] DEG_TO_RAD_Q32  = 36'sd74961321;

  localparam logic [DATA_W-2:0] TRACK_WIDTH_RST = 31'd655360;
  localparam logic [DATA_W-2:0] LR_OFFSET_RST   = 31'd327680;

  // operation codes
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_SET_POSE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USE_IMU     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_MIDDLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LR_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_OFFSET  = 3'd4;

  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO =
    {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  // atan(2^-i) in Q8.24
  function automatic logic signed [RES_W-1:0] atan_q24(input logic [STEP_W-1:0] i);
    logic signed [RES_W-1:0] v;
    case (i)
      5'd0:  v = 29'sd13176795;
      5'd1:  v = 29'sd7778716;
      5'd2:  v = 29'sd4110060;
      5'd3:  v = 29'sd2086331;
      5'd4:  v = 29'sd1047214;
      5'd5:  v = 29'sd524117;
      5'd6:  v = 29'sd262123;
      5'd7:  v = 29'sd131069;
      5'd8:  v = 29'sd65536;
      5'd9:  v = 29'sd32768;
      5'd10: v = 29'sd16384;
      5'd11: v = 29'sd8192;
      5'd12: v = 29'sd4096;
      5'd13: v = 29'sd2048;
      5'd14: v = 29'sd1024;
      5'd15: v = 29'sd512;
      5'd16: v = 29'sd256;
      5'd17: v = 29'sd128;
      5'd18: v = 29'sd64;
      5'd19: v = 29'sd32;
      5'd20: v = 29'sd16;
      5'd21: v = 29'sd8;
      5'd22: v = 29'sd4;
      5'd23: v = 29'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) r = SAT_HI[DATA_W-1:0];
    else if (v < SAT_LO) r = SAT_LO[DATA_W-1:0];
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  // rounded floor shift right by s
  function automatic logic signed [PROD_W-1:0] rasr(input logic signed [PROD_W-1:0] v,
                                                    input int s);
    logic signed [PROD_W-1:0] rnd;
    rnd = '0;
    rnd[s-1] = 1'b1;
    return (v + rnd) >>> s;
  endfunction

endpackage

@@ hdl/twodom_div.sv @@
// Iterative signed divider, truncating, two quotient bits per cycle.
module twodom_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [twodom_pkg::NUM_W-1:0]   num,
  input  logic signed [twodom_pkg::DEN_W-1:0]   den,
  output logic                                  done,
  output logic signed [twodom_pkg::NUM_W-1:0]   quot
);
  import twodom_pkg::*;

  localparam int ITERS = NUM_W / 2;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 neg_r;
  logic [NUM_W-1:0]     acc_r;   // dividend shifts out, quotient shifts in
  logic [DEN_W-1:0]     dmag_r;
  logic [DEN_W:0]       rem_r;
  logic [NUM_W-1:0]     acc_nxt;
  logic [DEN_W:0]       rem_nxt;

  always_comb begin
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    for (int j = 0; j < 2; j++) begin
      rem_nxt = {rem_nxt[DEN_W-1:0], acc_nxt[NUM_W-1]};
      acc_nxt = {acc_nxt[NUM_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dmag_r}) begin
        rem_nxt    = rem_nxt - {1'b0, dmag_r};
        acc_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // last iteration raises done for one cycle
      done_r <= busy_r && !start && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ITERS);
        neg_r  <= num[NUM_W-1] ^ den[DEN_W-1];
        acc_r  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dmag_r <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        rem_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule

@@ hdl/twodom_cordic.sv @@
// Iterative CORDIC sine/cosine with range reduction, one rotation per cycle.
module twodom_cordic (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [twodom_pkg::ANG_W-1:0]  angle,
  output logic                                 done,
  output logic signed [twodom_pkg::CS_W-1:0]   sin_o,
  output logic signed [twodom_pkg::CS_W-1:0]   cos_o
);
  import twodom_pkg::*;

  typedef enum logic [2:0] {C_IDLE, C_RED, C_FOLD_PI, C_FOLD_HALF, C_ITER} cst_t;

  cst_t                    st_r;
  logic                    done_r;
  logic                    neg_r;
  logic [ANG_W-1:0]        mag_r;
  logic [RED_W-1:0]        k_r;
  logic signed [RES_W-1:0] r_r;
  logic                    flip_r;
  logic signed [CS_W-1:0]  x_r, y_r;
  logic [STEP_W-1:0]       i_r;
  logic signed [CS_W-1:0]  sin_r, cos_r;

  logic [ANG_W-1:0]        thr;
  logic signed [RES_W-1:0] r0;
  logic signed [CS_W-1:0]  x_nxt, y_nxt;
  logic signed [RES_W-1:0] r_nxt;

  always_comb begin
    thr = ANG_W'(TWO_PI_Q24) << k_r;
    r0  = neg_r ? -$signed(mag_r[RES_W-1:0]) : $signed(mag_r[RES_W-1:0]);
    if (r_r >= 0) begin
      x_nxt = x_r - (y_r >>> i_r);
      y_nxt = y_r + (x_r >>> i_r);
      r_nxt = r_r - atan_q24(i_r);
    end else begin
      x_nxt = x_r + (y_r >>> i_r);
      y_nxt = y_r - (x_r >>> i_r);
      r_nxt = r_r + atan_q24(i_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == C_ITER) && (i_r == STEP_W'(CORDIC_STEPS - 1));
      unique case (st_r)
        C_IDLE: begin
          if (start) begin
            neg_r <= angle[ANG_W-1];
            mag_r <= angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);
            k_r   <= RED_W'(RED_STEPS - 1);
            st_r  <= C_RED;
          end
        end
        C_RED: begin
          // magnitude mod 2*pi, sign of the dividend kept
          if (mag_r >= thr) mag_r <= mag_r - thr;
          if (k_r == '0) st_r <= C_FOLD_PI;
          else k_r <= k_r - 1'b1;
        end
        C_FOLD_PI: begin
          if (r0 > PI_Q24) r_r <= r0 - TWO_PI_Q24;
          else if (r0 < -PI_Q24) r_r <= r0 + TWO_PI_Q24;
          else r_r <= r0;
          st_r <= C_FOLD_HALF;
        end
        C_FOLD_HALF: begin
          flip_r <= (r_r > HALF_PI_Q24) || (r_r < -HALF_PI_Q24);
          if (r_r > HALF_PI_Q24) begin
            r_r <= r_r - PI_Q24;
          end else if (r_r < -HALF_PI_Q24) begin
            r_r <= r_r + PI_Q24;
          end
          x_r  <= CORDIC_GAIN_Q30;
          y_r  <= '0;
          i_r  <= '0;
          st_r <= C_ITER;
        end
        C_ITER: begin
          x_r <= x_nxt;
          y_r <= y_nxt;
          r_r <= r_nxt;
          i_r <= i_r + 1'b1;
          if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
            sin_r  <= flip_r ? -y_nxt : y_nxt;
            cos_r  <= flip_r ? -x_nxt : x_nxt;
            st_r   <= C_IDLE;
          end
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

@@ hdl/tracking_wheel_odometry.sv @@
// Tracking-wheel arc odometry: sequencer, shared multiplier, pose and config registers.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_ready   | operation, left/right/middle dist, imu, new pose
//  out     | out_valid / out_ready | pos_x, pos_y, heading
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
// Work per item: a set pose goes straight to the done state; a sample with no heading
//   change takes one CORDIC pass, and the wheel heading divide before it in wheel mode;
//   a sample with a heading change takes two more divides and a second CORDIC pass.
//   The divider is radix-4 and the CORDIC does one rotation per cycle; a single 36x36
//   multiplier is shared across all products.
// Reset: synchronous, active low; pose, previous readings and registers take their
//   reset values at once, no clearing pass.
// Stalls: in_ready is high only while the sequencer is idle. A finished pose moves into
//   the output register; the next item may be taken while it waits for transfer, and a
//   further result waits in the done state until the output register is free.
module tracking_wheel_odometry (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic                                      in_operation,
  input  logic signed [twodom_pkg::DATA_W-1:0]      in_left_dist,
  input  logic signed [twodom_pkg::DATA_W-1:0]      in_right_dist,
  input  logic signed [twodom_pkg::DATA_W-1:0]      in_middle_dist,
  input  logic signed [twodom_pkg::DATA_W-1:0]      in_imu_rotation,
  input  logic signed [twodom_pkg::DATA_W-1:0]      in_new_x,
  input  logic signed [twodom_pkg::DATA_W-1:0]      in_new_y,
  input  logic signed [twodom_pkg::DATA_W-1:0]      in_new_heading,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [twodom_pkg::DATA_W-1:0]      out_pos_x,
  output logic signed [twodom_pkg::DATA_W-1:0]      out_pos_y,
  output logic signed [twodom_pkg::DATA_W-1:0]      out_heading,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [twodom_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [twodom_pkg::DATA_W-1:0]             cfg_data
);
  import twodom_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_IMU_MUL, S_IMU_HD, S_IMU_DA, S_W_START, S_W_WAIT, S_W_HD, S_CHK,
    S_A_START, S_A_WAIT, S_OX_MUL, S_OX, S_TX_START, S_TX_WAIT, S_OY_MUL, S_OY,
    S_TY_START, S_TY_WAIT, S_P_START, S_P_WAIT, S_X1, S_X2, S_X3, S_X4, S_Y1, S_Y2,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic                     use_imu_r, has_middle_r;
  logic [DATA_W-2:0]        tw_r, lro_r;
  logic signed [DATA_W-1:0] mo_r;

  // odometry state
  logic signed [DATA_W-1:0] last_left_r, last_right_r, last_middle_r, last_heading_r;
  logic signed [DATA_W-1:0] pose_x_r, pose_y_r, pose_heading_r;

  // per-item working registers
  logic signed [DATA_W-1:0] dl_r, dr_r, dm_r, imu_r, da_r, lx_r, ly_r;
  logic signed [CH_W-1:0]   ch_r;
  logic signed [OFF_W-1:0]  offx_r, offy_r;
  logic signed [CS_W-1:0]   sn_r, cs_r;
  logic signed [PROD_W-1:0] acc_r, prod_r;

  // output register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_x_r, out_y_r, out_h_r;

  // shared multiplier operands
  logic signed [MUL_W-1:0]  mul_a, mul_b;

  // divider and CORDIC hookup
  logic                     div_start, div_done;
  logic signed [NUM_W-1:0]  div_num, div_quot;
  logic signed [DEN_W-1:0]  div_den;
  logic                     cor_start, cor_done;
  logic signed [ANG_W-1:0]  cor_angle;
  logic signed [CS_W-1:0]   cor_sin, cor_cos;

  logic signed [DATA_W-1:0] in_mid_eff;
  logic signed [DATA_W-1:0] hd_imu, hd_sum;
  logic signed [DEN_W-1:0]  wheel_diff;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_pos_x = out_x_r;
  assign out_pos_y = out_y_r;
  assign out_heading = out_h_r;

  assign in_mid_eff = has_middle_r ? in_middle_dist : '0;
  assign hd_imu     = sat_data(rasr(-prod_r, 24));
  assign hd_sum     = sat_data(PROD_W'(pose_heading_r) + PROD_W'(da_r));
  assign wheel_diff = DEN_W'(dr_r) - DEN_W'(dl_r);

  // operand select for the shared multiplier; the product is registered in prod_r
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_IMU_MUL: begin mul_a = MUL_W'(imu_r);  mul_b = DEG_TO_RAD_Q32;   end
      S_OX_MUL:  begin mul_a = MUL_W'(lro_r);  mul_b = MUL_W'(ch_r);     end
      S_OX:      begin mul_a = MUL_W'(dr_r);   mul_b = MUL_W'(ch_r);     end
      S_OY_MUL:  begin mul_a = MUL_W'(mo_r);   mul_b = MUL_W'(ch_r);     end
      S_OY:      begin mul_a = MUL_W'(dm_r);   mul_b = MUL_W'(ch_r);     end
      S_X1:      begin mul_a = MUL_W'(cs_r);   mul_b = MUL_W'(lx_r);     end
      S_X2:      begin mul_a = MUL_W'(sn_r);   mul_b = MUL_W'(ly_r);     end
      S_X3:      begin mul_a = MUL_W'(cs_r);   mul_b = MUL_W'(ly_r);     end
      S_X4:      begin mul_a = MUL_W'(sn_r);   mul_b = MUL_W'(lx_r);     end
      default:   begin mul_a = '0;             mul_b = '0;               end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // divider: wheel heading, then the two arc terms
  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'(prod_r);
    div_den   = DEN_W'(da_r);
    case (state_r)
      S_W_START: begin
        div_start = 1'b1;
        div_num   = NUM_W'(wheel_diff) <<< 24;
        div_den   = (tw_r == '0) ? DEN_W'(1) : DEN_W'(tw_r);
      end
      S_TX_START, S_TY_START: div_start = 1'b1;
      default: div_start = 1'b0;
    endcase
  end

  // CORDIC: half the heading change, then the mid-step heading
  assign cor_start = (state_r == S_A_START) || (state_r == S_P_START);
  assign cor_angle = (state_r == S_A_START) ? ANG_W'(da_r >>> 1)
                                            : ANG_W'(pose_heading_r) - ANG_W'(da_r >>> 1);

  twodom_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  twodom_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .sin_o (cor_sin),
    .cos_o (cor_cos)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_imu_r    <= 1'b0;
      has_middle_r <= 1'b0;
      tw_r         <= TRACK_WIDTH_RST;
      lro_r        <= LR_OFFSET_RST;
      mo_r         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_USE_IMU:     use_imu_r    <= cfg_data[0];
        CFG_HAS_MIDDLE:  has_middle_r <= cfg_data[0];
        CFG_TRACK_WIDTH: tw_r         <= cfg_data[DATA_W-2:0];
        CFG_LR_OFFSET:   lro_r        <= cfg_data[DATA_W-2:0];
        CFG_MID_OFFSET:  mo_r         <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      last_left_r    <= '0;
      last_right_r   <= '0;
      last_middle_r  <= '0;
      last_heading_r <= '0;
      pose_x_r       <= '0;
      pose_y_r       <= '0;
      pose_heading_r <= '0;
    end else begin
      // a new result takes the output register once it is free
      if (state_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_operation == OP_SET_POSE) begin
              pose_x_r       <= in_new_x;
              pose_y_r       <= in_new_y;
              pose_heading_r <= in_new_heading;
              state_r        <= S_DONE;
            end else begin
              // deltas wrap modulo the data word
              dl_r          <= in_left_dist - last_left_r;
              dr_r          <= in_right_dist - last_right_r;
              dm_r          <= has_middle_r ? in_mid_eff - last_middle_r : '0;
              imu_r         <= in_imu_rotation;
              last_left_r   <= in_left_dist;
              last_right_r  <= in_right_dist;
              last_middle_r <= in_mid_eff;
              state_r       <= use_imu_r ? S_IMU_MUL : S_W_START;
            end
          end
        end
        S_IMU_MUL: state_r <= S_IMU_HD;
        S_IMU_HD: begin
          pose_heading_r <= hd_imu;
          state_r        <= S_IMU_DA;
        end
        S_IMU_DA: begin
          da_r           <= sat_data(PROD_W'(pose_heading_r) - PROD_W'(last_heading_r));
          last_heading_r <= pose_heading_r;
          state_r        <= S_CHK;
        end
        S_W_START: state_r <= S_W_WAIT;
        S_W_WAIT: begin
          if (div_done) begin
            da_r    <= sat_data(PROD_W'(div_quot));
            state_r <= S_W_HD;
          end
        end
        S_W_HD: begin
          pose_heading_r <= hd_sum;
          last_heading_r <= hd_sum;
          state_r        <= S_CHK;
        end
        S_CHK: begin
          if (da_r == '0) begin
            // straight motion
            lx_r    <= dr_r;
            ly_r    <= dm_r;
            state_r <= S_P_START;
          end else begin
            state_r <= S_A_START;
          end
        end
        S_A_START: state_r <= S_A_WAIT;
        S_A_WAIT: begin
          if (cor_done) begin
            ch_r    <= CH_W'(cor_sin) <<< 1;
            state_r <= S_OX_MUL;
          end
        end
        S_OX_MUL: state_r <= S_OX;
        S_OX: begin
          offx_r  <= OFF_W'(rasr(prod_r, 30));
          state_r <= S_TX_START;
        end
        S_TX_START: state_r <= S_TX_WAIT;
        S_TX_WAIT: begin
          if (div_done) begin
            lx_r    <= sat_data(rasr(PROD_W'(div_quot), 6) - PROD_W'(offx_r));
            state_r <= S_OY_MUL;
          end
        end
        S_OY_MUL: state_r <= S_OY;
        S_OY: begin
          offy_r  <= OFF_W'(rasr(prod_r, 30));
          state_r <= S_TY_START;
        end
        S_TY_START: state_r <= S_TY_WAIT;
        S_TY_WAIT: begin
          if (div_done) begin
            ly_r    <= sat_data(rasr(PROD_W'(div_quot), 6) + PROD_W'(offy_r));
            state_r <= S_P_START;
          end
        end
        S_P_START: state_r <= S_P_WAIT;
        S_P_WAIT: begin
          if (cor_done) begin
            sn_r    <= cor_sin;
            cs_r    <= cor_cos;
            state_r <= S_X1;
          end
        end
        S_X1: state_r <= S_X2;
        S_X2: begin
          acc_r   <= prod_r;                // cos*lx
          state_r <= S_X3;
        end
        S_X3: begin
          acc_r   <= acc_r - prod_r;        // - sin*ly
          state_r <= S_X4;
        end
        S_X4: begin
          pose_x_r <= sat_data(PROD_W'(pose_x_r) + rasr(acc_r, 30));
          acc_r    <= prod_r;               // cos*ly
          state_r  <= S_Y1;
        end
        S_Y1: begin
          acc_r   <= acc_r + prod_r;        // + sin*lx
          state_r <= S_Y2;
        end
        S_Y2: begin
          pose_y_r <= sat_data(PROD_W'(pose_y_r) + rasr(acc_r, 30));
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_x_r     <= pose_x_r;
            out_y_r     <= pose_y_r;
            out_h_r     <= pose_heading_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // set pose lands in the pose registers on the next cycle
  a_set_pose: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OP_SET_POSE) |=>
      (pose_x_r == $past(in_new_x) && pose_heading_r == $past(in_new_heading)))
    else $error("set pose not loaded");

  // divider only finishes while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_W_WAIT || state_r == S_TX_WAIT || state_r == S_TY_WAIT))
    else $error("unexpected divider completion");

  // CORDIC only finishes while the sequencer waits on it
  a_cor_done: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == S_A_WAIT || state_r == S_P_WAIT))
    else $error("unexpected CORDIC completion");

  // a result never overwrites one still waiting for transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_x_r)))
    else $error("output register overwritten");

endmodule

@@ sim/tb_tracking_wheel_odometry.sv @@
// Testbench for the tracking-wheel odometry block: self-checking pose predictor.
module tb_tracking_wheel_odometry;
  import twodom_pkg::*;

  // One input item and one pose result as seen on the ports
  typedef struct {
    logic op;
    int   left;
    int   right;
    int   middle;
    int   imu;
    int   nx;
    int   ny;
    int   nh;
  } odo_item_t;

  typedef struct {
    int x;
    int y;
    int hdg;
  } pose_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, in_operation;
  logic signed [DATA_W-1:0] in_left_dist, in_right_dist, in_middle_dist, in_imu_rotation;
  logic signed [DATA_W-1:0] in_new_x, in_new_y, in_new_heading;
  logic out_valid, out_ready;
  logic signed [DATA_W-1:0] out_pos_x, out_pos_y, out_heading;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  tracking_wheel_odometry dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------------
  // Pose predictor: its own copy of the registers and of the tracker state
  // ---------------------------------------------------------------------------
  localparam longint ATAN_TBL [CORDIC_STEPS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };
  localparam longint PI_L      = longint'(PI_Q24);
  localparam longint HALF_PI_L = longint'(HALF_PI_Q24);
  localparam longint TWO_PI_L  = longint'(TWO_PI_Q24);
  localparam longint GAIN_L    = longint'(CORDIC_GAIN_Q30);
  localparam longint DEG2RAD_L = longint'(DEG_TO_RAD_Q32);

  bit     m_use_imu, m_has_middle;
  longint m_track_width, m_lr_offset, m_mid_offset;
  longint prev_left, prev_right, prev_middle, prev_hdg;
  longint pose_x, pose_y, pose_hdg;

  pose_t  pending_poses[$];
  int     err_count;
  int     send_idle_pct, recv_stall_pct;
  int     quiet_cycles;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap32(input longint v);
    return longint'(int'(v));
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // range reduction into +-pi/2, then a 24-step rotation
  task automatic cordic_sin_cos(input longint ang, output longint sn, output longint cs);
    longint r, x, y, nx;
    bit flip;
    r = ang % TWO_PI_L;
    x = GAIN_L;
    y = 0;
    flip = 1'b0;
    if (r > PI_L) r -= TWO_PI_L;
    else if (r < -PI_L) r += TWO_PI_L;
    if (r > HALF_PI_L) begin
      r -= PI_L; flip = 1'b1;
    end else if (r < -HALF_PI_L) begin
      r += PI_L; flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        r -= ATAN_TBL[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        r += ATAN_TBL[i];
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  task automatic predict_pose(input odo_item_t it, output pose_t res);
    longint l, r, m, dl, dr, dm, da, lx, ly, sn, cs, p, ch, tw;
    if (it.op == OP_SET_POSE) begin
      pose_x = it.nx; pose_y = it.ny; pose_hdg = it.nh;
    end else begin
      l  = it.left;
      r  = it.right;
      m  = m_has_middle ? longint'(it.middle) : 0;
      dl = wrap32(l - prev_left);
      dr = wrap32(r - prev_right);
      dm = m_has_middle ? wrap32(m - prev_middle) : 0;
      if (m_use_imu) begin
        pose_hdg = clamp32(round_shift(-(longint'(it.imu) * DEG2RAD_L), 24));
        da = clamp32(pose_hdg - prev_hdg);
      end else begin
        tw = (m_track_width != 0) ? m_track_width : 1;   // zero width acts as one LSB
        da = clamp32(((dr - dl) * 64'sd16777216) / tw);
        pose_hdg = clamp32(pose_hdg + da);
      end
      prev_left = l; prev_right = r; prev_middle = m; prev_hdg = pose_hdg;
      if (da != 0) begin
        // arc: chord factor 2*sin(da/2) on offset-corrected radii
        cordic_sin_cos(da >>> 1, sn, cs);
        ch = sn * 2;
        lx = round_shift((dr * ch) / da, 6) - round_shift(m_lr_offset * ch, 30);
        ly = round_shift((dm * ch) / da, 6) + round_shift(m_mid_offset * ch, 30);
      end else begin
        lx = dr; ly = dm;
      end
      lx = clamp32(lx);
      ly = clamp32(ly);
      p = pose_hdg - (da >>> 1);
      cordic_sin_cos(p, sn, cs);
      pose_x = clamp32(pose_x + round_shift(cs * lx - sn * ly, 30));
      pose_y = clamp32(pose_y + round_shift(cs * ly + sn * lx, 30));
    end
    res.x = int'(pose_x);
    res.y = int'(pose_y);
    res.hdg = int'(pose_hdg);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers. All called at a rising edge; handshakes judged at the falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input odo_item_t it);
    pose_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= it.op;
    in_left_dist    <= it.left;
    in_right_dist   <= it.right;
    in_middle_dist  <= it.middle;
    in_imu_rotation <= it.imu;
    in_new_x        <= it.nx;
    in_new_y        <= it.ny;
    in_new_heading  <= it.nh;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_pose(it, res);
    pending_poses.push_back(res);
  endtask

  // registers only change once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    in_valid <= 1'b0;
    wait (pending_poses.size() == 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[DATA_W-1:0];
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_USE_IMU:     m_use_imu     = val[0];
      CFG_HAS_MIDDLE:  m_has_middle  = val[0];
      CFG_TRACK_WIDTH: m_track_width = longint'(val[30:0]);
      CFG_LR_OFFSET:   m_lr_offset   = longint'(val[30:0]);
      CFG_MID_OFFSET:  m_mid_offset  = longint'(int'(val[31:0]));
      default: ;
    endcase
  endtask

  function automatic odo_item_t sample(input int l, input int r, input int m, input int imu);
    odo_item_t it;
    it = '{op: OP_SAMPLE, left: l, right: r, middle: m, imu: imu,
           nx: int'($urandom), ny: int'($urandom), nh: int'($urandom)};
    return it;
  endfunction

  function automatic odo_item_t set_pose(input int x, input int y, input int h);
    odo_item_t it;
    it = '{op: OP_SET_POSE, left: int'($urandom), right: int'($urandom),
           middle: int'($urandom), imu: int'($urandom), nx: x, ny: y, nh: h};
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(negedge clk) begin
    pose_t exp_pose;
    if (rst_n && out_valid && out_ready) begin
      if (pending_poses.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result x=%0d y=%0d hdg=%0d", out_pos_x, out_pos_y, out_heading);
      end else begin
        exp_pose = pending_poses.pop_front();
        if (out_pos_x !== exp_pose.x || out_pos_y !== exp_pose.y ||
            out_heading !== exp_pose.hdg) begin
          err_count++;
          if (err_count <= 10)
            $display("pose mismatch: exp x=%0d y=%0d hdg=%0d, got x=%0d y=%0d hdg=%0d",
                     exp_pose.x, exp_pose.y, exp_pose.hdg, out_pos_x, out_pos_y, out_heading);
        end
      end
    end
  end

  // any transfer on any channel restarts the count
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // reset registers: wheel heading, no middle tracker
    send_item(sample(0, 0, 0, 0));                              // no motion
    send_item(sample(655360, 655360, 123, 0));                  // straight ahead
    send_item(sample(655360, 983040, 0, 0));                    // turn left
    send_item(sample(32'sh7fff_0000, 32'sh8000_0000, 0, 0));    // counter wrap, big turn
    send_item(sample(32'sh8000_0000, 32'sh7fff_ffff, 0, 0));
    send_item(set_pose(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ff00));
    send_item(sample(32'sh8000_0000, 32'sh8000_0000 + 32'sd600000, 0, 0)); // heading saturates
    send_item(set_pose(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
    send_item(sample(32'sh7fff_ffff, 32'sh8000_0000, 0, 0));    // x/y saturate
    // zero track width acts as one LSB
    write_reg(CFG_TRACK_WIDTH, 0);
    send_item(sample(32'sh8000_0000, 32'sh8000_0001, 0, 0));
    write_reg(CFG_TRACK_WIDTH, 32'h7fff_ffff);
    write_reg(CFG_HAS_MIDDLE, 1);
    write_reg(CFG_MID_OFFSET, 32'h8000_0000);
    write_reg(CFG_LR_OFFSET, 32'h7fff_ffff);
    send_item(sample(0, 65536, 32'sh7fff_ffff, 0));
    send_item(sample(-100000, 900000, 32'sh8000_0000, 0));
    write_reg(CFG_MID_OFFSET, 32'h7fff_ffff);
    write_reg(CFG_LR_OFFSET, 0);
    send_item(sample(-2000000, 4000000, -5000, 0));
    // IMU heading, extreme rotations, set pose then overwrite
    write_reg(CFG_USE_IMU, 1);
    send_item(sample(-2000000, 4100000, -4000, 32'sh8000_0000));
    send_item(sample(-1000000, 4200000, 0, 32'sh7fff_ffff));
    send_item(set_pose(1000, -1000, 5000000));
    send_item(sample(-1000000, 4200000, 0, 32'sh7fff_ffff));    // no motion, heading from IMU
    send_item(sample(0, 5000000, 77777, 90 <<< 16));
    // mode switch back to wheels, middle dropped
    write_reg(CFG_USE_IMU, 0);
    write_reg(CFG_HAS_MIDDLE, 0);
    send_item(sample(100, 5000100, 32'sh1234_5678, 0));
    write_reg(CFG_TRACK_WIDTH, 655360);
    write_reg(CFG_LR_OFFSET, 327680);
    write_reg(CFG_MID_OFFSET, 0);
    send_item(sample(200000, 5300000, 0, 0));
  endtask

  // new register settings, extremes now and then
  task automatic random_regs();
    int pick;
    write_reg(CFG_USE_IMU, $urandom_range(1));
    write_reg(CFG_HAS_MIDDLE, $urandom_range(1));
    pick = $urandom_range(9);
    write_reg(CFG_TRACK_WIDTH, pick == 0 ? 65536 : pick == 1 ? 32'h7fff_ffff :
              pick == 2 ? 0 : $urandom_range(32'h0200_0000, 65536));
    pick = $urandom_range(9);
    write_reg(CFG_LR_OFFSET, pick == 0 ? 0 : pick == 1 ? 32'h7fff_ffff :
              $urandom_range(32'h0010_0000));
    pick = $urandom_range(9);
    write_reg(CFG_MID_OFFSET, pick == 0 ? 32'h8000_0000 : pick == 1 ? 32'h7fff_ffff :
              longint'($urandom_range(32'h0020_0000)) - 64'sh0010_0000);
  endtask

  // mostly smooth motion from the last readings; some pose loads and wild readings
  task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
    int l, r, m, imu, kind, span;
    l = 0; r = 0; m = 0; imu = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) random_regs();
      kind = $urandom_range(99);
      span = ($urandom_range(3) == 0) ? 32'h0100_0000 : 32'h0004_0000;
      if (kind < 8) begin
        send_item(set_pose(int'($urandom), int'($urandom), int'($urandom)));
      end else if (kind < 16) begin
        l = $urandom; r = $urandom; m = $urandom; imu = $urandom;
        send_item(sample(l, r, m, imu));
      end else begin
        l   += int'($urandom_range(2 * span)) - span;
        r   += int'($urandom_range(2 * span)) - span;
        m   += int'($urandom_range(2 * span)) - span;
        imu += int'($urandom_range(32'h0040_0000)) - 32'h0020_0000;
        send_item(sample(l, r, m, imu));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_operation = OP_SAMPLE;
    in_left_dist = '0; in_right_dist = '0; in_middle_dist = '0; in_imu_rotation = '0;
    in_new_x = '0; in_new_y = '0; in_new_heading = '0;
    cfg_valid = 1'b0; cfg_index = CFG_USE_IMU; cfg_data = '0;
    err_count = 0; quiet_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    m_use_imu = 1'b0; m_has_middle = 1'b0;
    m_track_width = longint'(TRACK_WIDTH_RST);
    m_lr_offset = longint'(LR_OFFSET_RST);
    m_mid_offset = 0;
    prev_left = 0; prev_right = 0; prev_middle = 0; prev_hdg = 0;
    pose_x = 0; pose_y = 0; pose_hdg = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(640, 15, 71);
    test_random(640, 71, 15);
    test_random(640, 0, 0);

    in_valid <= 1'b0;
    wait (pending_poses.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_poses.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/twodom_pkg.sv
hdl/twodom_div.sv
hdl/twodom_cordic.sv
hdl/tracking_wheel_odometry.sv
sim/tb_tracking_wheel_odometry.sv
